// ===== rtl/core/drr_pkg.sv =====
// ----------------------------------------------------------------------------
// drr_pkg
// Shared constants and types for the dwell round-robin mode selector.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

    // Default configuration of the selector
    localparam int TABLE_ENTRIES_DEF = 7;
    localparam int MODE_BITS_DEF     = 4;
    localparam int GATE_BITS_DEF     = 16;
    localparam int BUDGET_BITS_DEF   = 8;
    localparam int MAX_PROBES_DEF    = 1792;

    // Mode codes
    localparam int STAY_MODE        = 12;
    localparam int FIRST_DWELL_MODE = 5;
    localparam int DWELL_MODES      = 6;
    localparam int DWELL_SLOT_W     = 3;

    // Result field widths
    localparam int SEL_MODE_W = 4;
    localparam int SEL_IDX_W  = 3;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ADVISORY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NICHE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MPLEX      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PPV        = 3'd6;

    // Mode table bits at or above this position always read as zero
    localparam int TABLE_VISIBLE_BITS = 64;

    // Width of the configuration write data: the widest register
    function automatic int cfg_width(input int gate_bits, input int table_bits,
                                     input int budget_bits);
        int w;
        w = 1;
        if (gate_bits > w)
            w = gate_bits;
        if (table_bits > w)
            w = table_bits;
        if (3 * budget_bits > w)
            w = 3 * budget_bits;
        return w;
    endfunction

    // Decision of one probe step
    typedef struct packed {
        logic done;          // walk ends with this probe
        logic stay;          // answer is the stay code
        logic dwell_we;      // dwell counter of the probed mode is written
        logic dwell_reload;  // written with its budget instead of the decrement
    } probe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/drr_req_if.sv =====
// ----------------------------------------------------------------------------
// drr_req_if
// Request channel of the mode selector: valid/ready with the request bit.
// ----------------------------------------------------------------------------
`default_nettype none

interface drr_req_if;
    logic valid;
    logic ready;
    logic request;

    modport source (output valid, output request, input ready);
    modport sink   (input valid, input request, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/drr_sel_if.sv =====
// ----------------------------------------------------------------------------
// drr_sel_if
// Result channel of the mode selector: valid/ready with mode and index.
// ----------------------------------------------------------------------------
`default_nettype none

interface drr_sel_if;
    logic                            valid;
    logic                            ready;
    logic [drr_pkg::SEL_MODE_W-1:0]  selected_mode;
    logic [drr_pkg::SEL_IDX_W-1:0]   next_index;

    modport source (output valid, output selected_mode, output next_index, input ready);
    modport sink   (input valid, input selected_mode, input next_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/drr_probe.sv =====
// ----------------------------------------------------------------------------
// drr_probe
// Decision logic for one table probe: accept, wrap, runaway and dwell update.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_probe #(
    parameter int MODE_BITS = drr_pkg::MODE_BITS_DEF,
    parameter int IDX_W     = 3
) (
    input  wire logic [MODE_BITS-1:0] mode,
    input  wire logic [IDX_W-1:0]     cand_next,
    input  wire logic [IDX_W-1:0]     start_idx,
    input  wire logic                 advisory,
    input  wire logic                 budget_nz,
    input  wire logic                 dec_zero,
    input  wire logic                 last_probe,
    output drr_pkg::probe_ctl_t       ctl
);

    logic in_range;
    logic is_stay;
    logic accept;
    logic wrapped;
    logic runaway;

    // Classify the probed code
    assign in_range = (mode >= MODE_BITS'(drr_pkg::FIRST_DWELL_MODE)) &&
                      (mode < MODE_BITS'(drr_pkg::FIRST_DWELL_MODE + drr_pkg::DWELL_MODES));
    assign is_stay  = (mode == MODE_BITS'(drr_pkg::STAY_MODE));

    // Accept: advisory on a nonzero budget, dwell on counter run-out or stay code
    always_comb
    begin
        if (in_range)
            accept = advisory ? budget_nz : (budget_nz && dec_zero);
        else
            accept = !advisory && is_stay;
    end

    // Advisory walk back at its start, or probe limit hit
    assign wrapped = !accept && advisory && (cand_next == start_idx);
    assign runaway = !accept && !wrapped && last_probe;

    assign ctl.done         = accept || wrapped || runaway;
    assign ctl.stay         = wrapped || runaway;
    assign ctl.dwell_we     = in_range && !advisory && budget_nz;
    assign ctl.dwell_reload = in_range && !advisory && budget_nz && dec_zero;

endmodule

`default_nettype wire

// ===== rtl/core/dwell_round_robin_mode_select.sv =====
// ----------------------------------------------------------------------------
// dwell_round_robin_mode_select
// Picks the next display mode from a mode table, one probe per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   req  (sink)   : one request bit per item; 1 asks for the next mode.
//   sel  (source) : one result per request: selected_mode (12 = stay put)
//                   and next_index, the table index of the next walk.
//   cfg_we/cfg_index/cfg_data : register writes, to be taken only while
//     idle; the user must keep to this, the block does not enforce it.
// Sequencing (one probe unit, one sequencer):
//   A request of 0, or one held by the advisory gate, goes from idle to
//   the finish state, which loads the result register when the slot is
//   free. A walk reads table entries in turn until a probe accepts, an
//   advisory walk comes back to its start, or the MAX_PROBES limit is hit.
//   req.ready is high only while the sequencer is idle, so a new request
//   waits until the last one has reached the result register.
// Stalls:
//   The result register holds its item until sel.ready; a new request is
//   still accepted meanwhile, and its walk waits at the end for the slot.
// Reset:
//   rst_n clears the configuration registers, the state, gate countdown,
//   walk index, dwell counters and result valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dwell_round_robin_mode_select #(
    parameter int TABLE_ENTRIES = drr_pkg::TABLE_ENTRIES_DEF,
    parameter int MODE_BITS     = drr_pkg::MODE_BITS_DEF,
    parameter int GATE_BITS     = drr_pkg::GATE_BITS_DEF,
    parameter int BUDGET_BITS   = drr_pkg::BUDGET_BITS_DEF,
    parameter int MAX_PROBES    = drr_pkg::MAX_PROBES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    drr_req_if.sink                                  req,
    drr_sel_if.source                                sel,
    input  wire logic                                cfg_we,
    input  wire logic [drr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [drr_pkg::cfg_width(GATE_BITS, TABLE_ENTRIES * MODE_BITS,
                                          BUDGET_BITS)-1:0] cfg_data
);

    localparam int TBITS   = TABLE_ENTRIES * MODE_BITS;
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int PROBE_W = $clog2(MAX_PROBES + 1);
    localparam int VBITS   = 3 * BUDGET_BITS;
    localparam int SLOT_W  = drr_pkg::DWELL_SLOT_W;

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // Table bits beyond the visible range read as zero
    function automatic logic [TBITS-1:0] table_keep();
        logic [TBITS-1:0] m;
        for (int i = 0; i < TBITS; i++)
            m[i] = (i < drr_pkg::TABLE_VISIBLE_BITS);
        return m;
    endfunction

    localparam logic [TBITS-1:0] TABLE_KEEP = table_keep();

    // Configuration registers
    logic                   advisory_reg;
    logic [GATE_BITS-1:0]   gate_dur_reg;
    logic [TBITS-1:0]       table_reg;
    logic [VBITS-1:0]       variant_reg;
    logic [BUDGET_BITS-1:0] niche_reg;
    logic [BUDGET_BITS-1:0] mplex_reg;
    logic [BUDGET_BITS-1:0] ppv_reg;

    // Walk state
    logic [1:0]             state_reg,  state_next;
    logic [GATE_BITS-1:0]   gate_cnt_reg, gate_cnt_next;
    logic [IDX_W-1:0]       cand_reg,   cand_next;
    logic [IDX_W-1:0]       start_reg,  start_next;
    logic [PROBE_W-1:0]     probe_reg,  probe_next;
    logic [BUDGET_BITS-1:0] dwell_reg [drr_pkg::DWELL_MODES];
    logic [drr_pkg::SEL_MODE_W-1:0] res_mode_reg, res_mode_next;
    logic                   sel_valid_reg, sel_valid_next;
    logic [drr_pkg::SEL_MODE_W-1:0] sel_mode_reg;
    logic [drr_pkg::SEL_IDX_W-1:0]  sel_idx_reg;

    logic                   in_fire;
    logic                   slot_free;
    logic [MODE_BITS-1:0]   mode;
    logic [IDX_W-1:0]       cand_step;
    logic [SLOT_W-1:0]      slot;
    logic [BUDGET_BITS-1:0] budget;
    logic [BUDGET_BITS-1:0] dwell_dec;
    logic                   last_probe;
    logic [31:0]            cand_wide;
    drr_pkg::probe_ctl_t    ctl;

    // ------------------------------------------------------------------
    // Register writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            advisory_reg <= 1'b0;
            gate_dur_reg <= '0;
            table_reg    <= '0;
            variant_reg  <= '0;
            niche_reg    <= '0;
            mplex_reg    <= '0;
            ppv_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                drr_pkg::REG_ADVISORY: advisory_reg <= cfg_data[0];
                drr_pkg::REG_GATE:     gate_dur_reg <= cfg_data[GATE_BITS-1:0];
                drr_pkg::REG_TABLE:    table_reg    <= cfg_data[TBITS-1:0] & TABLE_KEEP;
                drr_pkg::REG_VARIANT:  variant_reg  <= cfg_data[VBITS-1:0];
                drr_pkg::REG_NICHE:    niche_reg    <= cfg_data[BUDGET_BITS-1:0];
                drr_pkg::REG_MPLEX:    mplex_reg    <= cfg_data[BUDGET_BITS-1:0];
                drr_pkg::REG_PPV:      ppv_reg      <= cfg_data[BUDGET_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Probe datapath: table read, budget and dwell counter of the mode
    // ------------------------------------------------------------------
    assign mode = table_reg[cand_reg * MODE_BITS +: MODE_BITS];

    // Index advance: a stay code restarts at entry 0, last entry wraps
    always_comb
    begin
        if (mode == MODE_BITS'(drr_pkg::STAY_MODE) ||
            cand_reg == IDX_W'(TABLE_ENTRIES - 1))
            cand_step = '0;
        else
            cand_step = cand_reg + IDX_W'(1);
    end

    assign slot = SLOT_W'(mode - MODE_BITS'(drr_pkg::FIRST_DWELL_MODE));

    // Budget of the probed dwell slot
    always_comb
    begin
        case (slot)
            3'd0:    budget = niche_reg;
            3'd1:    budget = variant_reg[0 +: BUDGET_BITS];
            3'd2:    budget = variant_reg[BUDGET_BITS +: BUDGET_BITS];
            3'd3:    budget = variant_reg[2 * BUDGET_BITS +: BUDGET_BITS];
            3'd4:    budget = mplex_reg;
            default: budget = ppv_reg;
        endcase
    end

    assign dwell_dec  = dwell_reg[(slot < SLOT_W'(drr_pkg::DWELL_MODES)) ? slot : '0]
                        - BUDGET_BITS'(1);
    assign last_probe = (probe_reg == PROBE_W'(MAX_PROBES - 1));

    drr_probe #(
        .MODE_BITS (MODE_BITS),
        .IDX_W     (IDX_W)
    ) u_probe (
        .mode       (mode),
        .cand_next  (cand_step),
        .start_idx  (start_reg),
        .advisory   (advisory_reg),
        .budget_nz  (budget != '0),
        .dec_zero   (dwell_dec == '0),
        .last_probe (last_probe),
        .ctl        (ctl)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign in_fire   = req.valid && req.ready;
    assign slot_free = !sel_valid_reg || sel.ready;

    always_comb
    begin
        state_next    = state_reg;
        gate_cnt_next = gate_cnt_reg;
        cand_next     = cand_reg;
        start_next    = start_reg;
        probe_next    = probe_reg;
        res_mode_next = res_mode_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    res_mode_next = drr_pkg::SEL_MODE_W'(drr_pkg::STAY_MODE);
                    probe_next    = '0;
                    start_next    = cand_reg;
                    state_next    = S_FIN;
                    if (req.request)
                    begin
                        if (!advisory_reg)
                            state_next = S_WALK;
                        else if (gate_dur_reg != '0)
                        begin
                            if (gate_cnt_reg != '0)
                                gate_cnt_next = gate_cnt_reg - GATE_BITS'(1);
                            else
                            begin
                                gate_cnt_next = gate_dur_reg;
                                state_next    = S_WALK;
                            end
                        end
                    end
                end
            end
            S_WALK:
            begin
                cand_next  = cand_step;
                probe_next = probe_reg + PROBE_W'(1);
                if (ctl.done)
                begin
                    res_mode_next = ctl.stay ? drr_pkg::SEL_MODE_W'(drr_pkg::STAY_MODE)
                                             : mode[drr_pkg::SEL_MODE_W-1:0];
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            gate_cnt_reg <= '0;
            cand_reg     <= '0;
            start_reg    <= '0;
            probe_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            gate_cnt_reg <= gate_cnt_next;
            cand_reg     <= cand_next;
            start_reg    <= start_next;
            probe_reg    <= probe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_mode_reg <= res_mode_next;
    end

    // Dwell counters, one per mode 5..10
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < drr_pkg::DWELL_MODES; i++)
                dwell_reg[i] <= '0;
        end
        else if (state_reg == S_WALK && ctl.dwell_we)
        begin
            for (int i = 0; i < drr_pkg::DWELL_MODES; i++)
                if (slot == SLOT_W'(i))
                    dwell_reg[i] <= ctl.dwell_reload ? budget : dwell_dec;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    assign cand_wide = 32'(cand_reg);

    always_comb
    begin
        sel_valid_next = sel_valid_reg && !sel.ready;
        if (state_reg == S_FIN && slot_free)
            sel_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else
            sel_valid_reg <= sel_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && slot_free)
        begin
            sel_mode_reg <= res_mode_reg;
            sel_idx_reg  <= cand_wide[drr_pkg::SEL_IDX_W-1:0];
        end
    end

    assign sel.valid         = sel_valid_reg;
    assign sel.selected_mode = sel_mode_reg;
    assign sel.next_index    = sel_idx_reg;

endmodule

`default_nettype wire
